@@ design/text_console_escape_writer_unit_macros.svh @@
// Assertion macros shared by the console writer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef TEXT_CONSOLE_ESCAPE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_ESCAPE_WRITER_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TCEW_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never hold.
`define TCEW_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

`endif

@@ design/tcew_pkg.sv @@
// Package for the text console escape writer: payload structs, command format,
// character constants and escape form tables. No dependencies.
`timescale 1ns / 1ps

package tcew_pkg;

    localparam int CELL_INDEX_W = 11;
    localparam int POS_W        = 7;
    localparam int HELD_DEPTH   = 6;
    localparam int HELD_CNT_W   = 3;
    localparam int CMD_DEPTH    = 4;
    localparam int CMD_PTR_W    = 2;
    localparam int CMD_CNT_W    = 3;
    localparam int NUM_FORMS    = 6;

    localparam logic [7:0] CH_LBRACK   = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LOWER_M  = 8'h6D;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_THREE    = 8'h33;
    localparam logic [7:0] CH_FOUR     = 8'h34;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] DEL_BYTE    = 8'h7F;
    localparam logic [7:0] COLOR_RESET = 8'h0F;

    // Escape forms in match priority order
    localparam logic [2:0] FORM_FG  = 3'd0;  // 3cm
    localparam logic [2:0] FORM_BG  = 3'd1;  // 4cm
    localparam logic [2:0] FORM_P11 = 3'd2;  // R;Cf
    localparam logic [2:0] FORM_P12 = 3'd3;  // R;CCf
    localparam logic [2:0] FORM_P21 = 3'd4;  // RR;Cf
    localparam logic [2:0] FORM_P22 = 3'd5;  // RR;CCf

    localparam logic [2:0] FORM_LEN [NUM_FORMS] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6};
    localparam logic [2:0] FORM_PA  [NUM_FORMS] = '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2};
    localparam logic [7:0] FORM_CA  [NUM_FORMS] =
        '{CH_THREE, CH_FOUR, CH_SEMI, CH_SEMI, CH_SEMI, CH_SEMI};
    localparam logic [2:0] FORM_PB  [NUM_FORMS] = '{3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5};
    localparam logic [7:0] FORM_CB  [NUM_FORMS] =
        '{CH_LOWER_M, CH_LOWER_M, CH_LOWER_F, CH_LOWER_F, CH_LOWER_F, CH_LOWER_F};

    typedef struct packed {
        logic [7:0] text_byte;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed {
        logic [CELL_INDEX_W-1:0] cell_index;
        logic [15:0]             cell_value;
        logic                    run_last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_PLAIN,
        OP_FG,
        OP_BG,
        OP_POS
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [7:0]       data;      // character, or color nibble in [3:0]
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             run_last;
    } cmd_t;

endpackage

@@ design/text_console_escape_writer_unit.sv @@
// Text console escape writer: byte stream in, screen cell writes out.
//
// s_ channel takes one text byte (plus a buffer-end mark) per transfer; m_
// channel delivers cell writes {cell_index, cell_value, run_last}, with
// run_last set on the last cell write caused by one input byte.
// A byte's cell write goes through the command queue and output register.
// Plain bytes and bytes inside an escape sequence are taken one per cycle.
// When an escape sequence fails or its buffer ends, the parser replays the
// held bytes (and the breaking byte, unless it reopens an escape) into the
// command queue one per cycle while it has room, up to 6 bytes; s_ready
// is low during the replay. The back end writes one cell per cycle.
// A four-entry command queue sits between parser and cell writer; when the
// receiver stalls, the output register holds, the queue fills, and s_ready
// drops until room opens again.
// Reset puts the cursor at cell 0, color to white on black (0x0F) and the
// parser to idle; the queue and output register are emptied.
// Depends on tcew_pkg, tcew_front, tcew_cmd_fifo and tcew_back.
`timescale 1ns / 1ps

module text_console_escape_writer_unit import tcew_pkg::*; #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic fifo_full, fifo_empty;
    logic push, pop;
    cmd_t push_cmd, pop_cmd;

    tcew_front #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tcew_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (fifo_full),
        .empty    (fifo_empty),
        .pop_cmd  (pop_cmd)
    );

    tcew_back #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_empty (fifo_empty),
        .cmd       (pop_cmd),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ design/tcew_front.sv @@
// Front end: accepts bytes, runs the escape parser, replays held bytes and
// pushes commands into the queue. Depends on tcew_pkg and the macro header.
`timescale 1ns / 1ps
`include "text_console_escape_writer_unit_macros.svh"

module tcew_front import tcew_pkg::*; #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     fifo_full,
    output logic     push,
    output cmd_t     push_cmd
);

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'b01,
        ST_REPLAY = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic                  phase_reg, phase_next;
    logic [HELD_CNT_W-1:0] held_cnt_reg, held_cnt_next;
    logic [HELD_CNT_W-1:0] rep_cnt_reg, rep_cnt_next;
    logic                  tail_open_reg, tail_open_next;
    logic [7:0]            held_reg [HELD_DEPTH];

    logic                  accept;
    logic [7:0]            b;
    logic                  is_end;
    logic [HELD_CNT_W-1:0] len;
    logic [7:0]            s_ch [HELD_DEPTH];
    logic                  in_len [HELD_DEPTH];
    logic [NUM_FORMS-1:0]  compat, full_m, viab;
    logic [2:0]            sel;
    logic                  any_full, viable;
    logic                  two_r, two_c;
    logic [7:0]            c0, c1;
    logic                  row_ok, col_ok, pos_ok;
    logic [POS_W-1:0]      row_val, col_val;
    logic                  tail_plain, tail_open;
    logic                  hold_wr, shift_en;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Two-digit value; digit codes carry their value in the low nibble
    function automatic logic [POS_W-1:0] two_dig(input logic [7:0] hi, input logic [7:0] lo);
        return POS_W'(hi[3:0]) * POS_W'(10) + POS_W'(lo[3:0]);
    endfunction

    assign b       = s_data.text_byte;
    assign is_end  = s_data.buffer_end;
    assign s_ready = (state_reg == ST_ACCEPT) && !fifo_full;
    assign accept  = s_valid && s_ready;
    assign len     = held_cnt_reg + HELD_CNT_W'(1);

    // Candidate sequence: held bytes followed by the incoming byte
    always_comb begin
        for (int p = 0; p < HELD_DEPTH; p++) begin
            in_len[p] = (HELD_CNT_W'(p) <= held_cnt_reg);
            s_ch[p]   = (HELD_CNT_W'(p) < held_cnt_reg) ? held_reg[p] : b;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_FORMS; i++) begin
            compat[i] = (!in_len[FORM_PA[i]] || (s_ch[FORM_PA[i]] == FORM_CA[i])) &&
                        (!in_len[FORM_PB[i]] || (s_ch[FORM_PB[i]] == FORM_CB[i]));
            full_m[i] = compat[i] && (FORM_LEN[i] == len);
            viab[i]   = compat[i] && (FORM_LEN[i] > len);
        end
        sel = FORM_FG;
        for (int i = NUM_FORMS - 1; i >= 0; i--) begin
            if (full_m[i]) begin
                sel = 3'(i);
            end
        end
    end

    assign any_full = |full_m;
    assign viable   = |viab;

    assign two_r = (sel == FORM_P21) || (sel == FORM_P22);
    assign two_c = (sel == FORM_P12) || (sel == FORM_P22);
    assign c0    = two_r ? s_ch[3] : s_ch[2];
    assign c1    = two_r ? s_ch[4] : s_ch[3];

    assign row_ok  = is_dig(s_ch[0]) && (!two_r || is_dig(s_ch[1]));
    assign col_ok  = is_dig(c0) && (!two_c || is_dig(c1));
    assign row_val = two_r ? two_dig(s_ch[0], s_ch[1]) : POS_W'(s_ch[0][3:0]);
    assign col_val = two_c ? two_dig(c0, c1) : POS_W'(c0[3:0]);
    assign pos_ok  = row_ok && col_ok &&
                     (row_val < POS_W'(SCREEN_ROWS)) && (col_val < POS_W'(SCREEN_COLS));

    // After a failed sequence the breaking byte is written, or, if it is [, reopens an escape (dropped at buffer end)
    assign tail_plain = viable || (b != CH_LBRACK);
    assign tail_open  = !viable && (b == CH_LBRACK) && !is_end;

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        held_cnt_next  = held_cnt_reg;
        rep_cnt_next   = rep_cnt_reg;
        tail_open_next = tail_open_reg;
        hold_wr        = 1'b0;
        shift_en       = 1'b0;
        push           = 1'b0;
        push_cmd       = '{op: OP_PLAIN, data: b, row: row_val, col: col_val,
                           run_last: 1'b1};
        case (state_reg)
            ST_ACCEPT: begin
                if (accept) begin
                    if (!phase_reg) begin
                        if (b == CH_LBRACK) begin
                            if (!is_end) begin
                                phase_next    = 1'b1;
                                held_cnt_next = '0;
                            end
                        end else begin
                            push = 1'b1;
                        end
                    end else if (any_full) begin
                        phase_next    = 1'b0;
                        held_cnt_next = '0;
                        push_cmd.data = {4'h0, s_ch[1][3:0]};
                        if (sel == FORM_FG) begin
                            push_cmd.op = OP_FG;
                            push        = 1'b1;
                        end else if (sel == FORM_BG) begin
                            push_cmd.op = OP_BG;
                            push        = 1'b1;
                        end else begin
                            push_cmd.op = OP_POS;
                            push        = pos_ok;
                        end
                    end else if (viable && !is_end) begin
                        hold_wr       = 1'b1;
                        held_cnt_next = len;
                    end else begin
                        hold_wr        = 1'b1;
                        phase_next     = 1'b0;
                        held_cnt_next  = '0;
                        rep_cnt_next   = held_cnt_reg + HELD_CNT_W'(tail_plain);
                        tail_open_next = tail_open;
                        if (held_cnt_reg == '0 && !tail_plain) begin
                            phase_next = tail_open;
                        end else begin
                            state_next = ST_REPLAY;
                        end
                    end
                end
            end
            ST_REPLAY: begin
                push_cmd.data     = held_reg[0];
                push_cmd.run_last = (rep_cnt_reg == HELD_CNT_W'(1));
                if (!fifo_full) begin
                    push         = 1'b1;
                    shift_en     = 1'b1;
                    rep_cnt_next = rep_cnt_reg - HELD_CNT_W'(1);
                    if (rep_cnt_reg == HELD_CNT_W'(1)) begin
                        state_next = ST_ACCEPT;
                        phase_next = tail_open_reg;
                    end
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCEPT;
            phase_reg     <= 1'b0;
            held_cnt_reg  <= '0;
            rep_cnt_reg   <= '0;
            tail_open_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            held_cnt_reg  <= held_cnt_next;
            rep_cnt_reg   <= rep_cnt_next;
            tail_open_reg <= tail_open_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_wr) begin
            held_reg[held_cnt_reg] <= b;
        end else if (shift_en) begin
            for (int i = 0; i < HELD_DEPTH - 1; i++) begin
                held_reg[i] <= held_reg[i+1];
            end
        end
    end

    `TCEW_ASSERT_IMP(a_replay_has_work, aclk, aresetn, state_reg == ST_REPLAY,
        rep_cnt_reg != '0, "replay state with nothing left to replay")
    `TCEW_ASSERT_NEVER(a_held_in_range, aclk, aresetn,
        held_cnt_reg > HELD_CNT_W'(HELD_DEPTH - 1), "held byte count out of range")
    `TCEW_ASSERT_NEVER(a_no_push_when_full, aclk, aresetn, push && fifo_full,
        "command pushed into a full queue")

endmodule

@@ design/tcew_cmd_fifo.sv @@
// Short command queue between parser front end and cell writer back end.
// Depends on tcew_pkg and the macro header.
`timescale 1ns / 1ps
`include "text_console_escape_writer_unit_macros.svh"

module tcew_cmd_fifo import tcew_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t pop_cmd
);

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic                 do_push, do_pop;

    assign full    = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + CMD_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + CMD_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CMD_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CMD_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `TCEW_ASSERT_NEVER(a_count_in_range, aclk, aresetn,
        count_reg > CMD_CNT_W'(CMD_DEPTH), "queue count exceeds depth")

endmodule

@@ design/tcew_back.sv @@
// Back end: executes queued commands, owns cursor and color, and drives the
// registered result channel. Depends on tcew_pkg and the macro header.
`timescale 1ns / 1ps
`include "text_console_escape_writer_unit_macros.svh"

module tcew_back import tcew_pkg::*; #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cmd_empty,
    input  cmd_t      cmd,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
    localparam int CUR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LIN_W = 2 * POS_W;

    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [7:0]       color_reg, color_next;
    logic             m_valid_reg;
    out_item_t        m_data_reg, m_data_next;
    logic             out_free;
    logic [CUR_W:0]   cur_inc;
    logic [LIN_W-1:0] pos_lin;

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = !cmd_empty && out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign cur_inc = {1'b0, cursor_reg} + (CUR_W+1)'(1);
    assign pos_lin = LIN_W'(cmd.row) * LIN_W'(SCREEN_COLS) + LIN_W'(cmd.col);

    always_comb begin
        cursor_next = cursor_reg;
        color_next  = color_reg;
        m_data_next = '{cell_index: CELL_INDEX_W'(cursor_reg),
                        cell_value: {color_reg, cmd.data},
                        run_last:   cmd.run_last};
        case (cmd.op)
            OP_PLAIN: begin
                if (cmd.data == DEL_BYTE) begin
                    // delete at cell zero blanks cell zero and stays there
                    if (cursor_reg != '0) begin
                        cursor_next = cursor_reg - CUR_W'(1);
                    end
                    m_data_next.cell_index = CELL_INDEX_W'(cursor_next);
                    m_data_next.cell_value = {color_reg, CH_SPACE};
                end else begin
                    cursor_next = (cur_inc >= (CUR_W+1)'(CELLS)) ? '0 : cur_inc[CUR_W-1:0];
                end
            end
            OP_FG: begin
                color_next = {color_reg[7:4], cmd.data[3:0]};
            end
            OP_BG: begin
                color_next = {cmd.data[3:0], color_reg[3:0]};
            end
            OP_POS: begin
                cursor_next = CUR_W'(pos_lin);
            end
            default: begin
                cursor_next = cursor_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg  <= '0;
            color_reg   <= COLOR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                cursor_reg <= cursor_next;
                color_reg  <= color_next;
            end
            if (out_free) begin
                m_valid_reg <= pop && (cmd.op == OP_PLAIN);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= m_data_next;
        end
    end

    `TCEW_ASSERT_NEVER(a_cursor_on_screen, aclk, aresetn,
        {1'b0, cursor_reg} >= (CUR_W+1)'(CELLS), "cursor left the screen")

endmodule
